// ----- hdl/nns_pkg.sv -----
// nns_pkg: shared types and constants for the nearest node search block
// payload structs, command codes and derived widths
// no dependencies

package nns_pkg;

    localparam int MAX_NODES = 1024;
    localparam int ADDR_W    = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int CNT_W     = $clog2(MAX_NODES + 1);
    localparam int COORD_W   = 24;
    localparam int SQ_W      = 2 * COORD_W;
    localparam int DIST_W    = 50;
    localparam int INDEX_W   = 10;
    localparam int DIM_W     = 2;
    localparam int CMD_W     = 2;

    localparam logic [DIST_W-1:0] DIST_NONE = DIST_W'(3) << SQ_W;

    localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_QUERY = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

    localparam logic [DIM_W-1:0] DIM_ONE   = 2'd1;
    localparam logic [DIM_W-1:0] DIM_TWO   = 2'd2;
    localparam logic [DIM_W-1:0] DIM_THREE = 2'd3;

    typedef struct packed {
        logic [CMD_W-1:0]          cmd;
        logic signed [COORD_W-1:0] coord_x;
        logic signed [COORD_W-1:0] coord_y;
        logic signed [COORD_W-1:0] coord_z;
    } in_item_t;

    typedef struct packed {
        logic                found;
        logic [INDEX_W-1:0]  nearest_index;
        logic [DIST_W-1:0]   sq_distance;
    } out_item_t;

endpackage

// ----- hdl/nearest_node_search.sv -----
// nearest_node_search: node table in one synchronous memory with a pipelined scan
// uses nns_pkg for payload types, widths and command codes
// load and clear transactions leave input open, so they can follow back to back
// a query raises out_valid once it has scanned every stored node and drained the pipeline
// (SCAN, DRAIN, DONE), and input reopens in that cycle; an unread earlier result delays both
// reset empties the table and sets dimensions to 3; memory contents are kept

module nearest_node_search
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  nns_pkg::in_item_t            in_data,
    output logic                         out_valid,
    input  logic                         out_ready,
    output nns_pkg::out_item_t           out_data,
    input  logic                         cfg_wr_en,
    input  logic [nns_pkg::DIM_W-1:0]    cfg_wr_data
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    localparam int ENTRY_W = 3 * nns_pkg::COORD_W;

    typedef logic [nns_pkg::COORD_W-1:0] mag_t;

    function automatic mag_t abs_diff(input logic signed [nns_pkg::COORD_W-1:0] a,
                                      input logic signed [nns_pkg::COORD_W-1:0] b);
        logic signed [nns_pkg::COORD_W:0] d;
        logic [nns_pkg::COORD_W:0]        m;
        d = {a[nns_pkg::COORD_W-1], a} - {b[nns_pkg::COORD_W-1], b};
        m = d[nns_pkg::COORD_W] ? (~d + 1'b1) : d;
        return m[nns_pkg::COORD_W-1:0];
    endfunction

    logic [ENTRY_W-1:0] node_mem [nns_pkg::MAX_NODES];

    logic [1:0]                       state_reg, state_next;
    logic [nns_pkg::DIM_W-1:0]        dim_reg;
    logic [nns_pkg::CNT_W-1:0]        count_reg, count_next;
    logic [nns_pkg::CNT_W-1:0]        addr_reg, addr_next;
    logic [nns_pkg::DIM_W-1:0]        qdim_reg;
    logic signed [nns_pkg::COORD_W-1:0] qx_reg, qy_reg, qz_reg;

    logic                             rd_en;
    logic                             wr_en;
    logic                             accept;

    logic                             v1_reg, v2_reg, v3_reg, v4_reg;
    logic [ENTRY_W-1:0]               rdata_reg;
    logic [nns_pkg::ADDR_W-1:0]       idx1_reg, idx2_reg, idx3_reg, idx4_reg;
    mag_t                             ax_reg, ay_reg, az_reg;
    mag_t                             ax_next, ay_next, az_next;
    logic [nns_pkg::SQ_W-1:0]         sqx_reg, sqy_reg, sqz_reg;
    logic [nns_pkg::DIST_W-1:0]       sum_reg;

    logic                             best_found_reg;
    logic [nns_pkg::ADDR_W-1:0]       best_idx_reg;
    logic [nns_pkg::DIST_W-1:0]       best_dist_reg;
    logic                             take_best;

    logic                             out_valid_reg;
    nns_pkg::out_item_t               out_data_reg;
    logic                             out_load;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;
    assign wr_en    = accept && (in_data.cmd == nns_pkg::CMD_LOAD)
                      && (count_reg < nns_pkg::CNT_W'(nns_pkg::MAX_NODES));
    assign rd_en    = (state_reg == ST_SCAN) && (addr_reg != count_reg);
    assign out_load = (state_reg == ST_DONE) && (!out_valid_reg || out_ready);
    assign take_best = v4_reg && (!best_found_reg || (sum_reg < best_dist_reg));

    // node table
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            node_mem[count_reg[nns_pkg::ADDR_W-1:0]] <= {in_data.coord_x, in_data.coord_y,
                                                         in_data.coord_z};
        end
        if (rd_en)
        begin
            rdata_reg <= node_mem[addr_reg[nns_pkg::ADDR_W-1:0]];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        addr_next  = addr_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    priority if (in_data.cmd == nns_pkg::CMD_LOAD)
                    begin
                        if (wr_en)
                        begin
                            count_next = count_reg + 1'b1;
                        end
                    end
                    else if (in_data.cmd == nns_pkg::CMD_CLEAR)
                    begin
                        count_next = '0;
                    end
                    else if (in_data.cmd == nns_pkg::CMD_QUERY)
                    begin
                        state_next = ST_SCAN;
                        addr_next  = '0;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_SCAN:
            begin
                if (rd_en)
                begin
                    addr_next = addr_reg + 1'b1;
                end
                else
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!v1_reg && !v2_reg && !v3_reg && !v4_reg)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            addr_reg      <= '0;
            dim_reg       <= nns_pkg::DIM_THREE;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            addr_reg  <= addr_next;
            v1_reg    <= rd_en;
            v2_reg    <= v1_reg;
            v3_reg    <= v2_reg;
            v4_reg    <= v3_reg;
            if (cfg_wr_en)
            begin
                dim_reg <= cfg_wr_data;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // query operands and per-axis magnitudes
    always_comb
    begin
        ax_next = abs_diff(rdata_reg[3*nns_pkg::COORD_W-1:2*nns_pkg::COORD_W], qx_reg);
        ay_next = abs_diff(rdata_reg[2*nns_pkg::COORD_W-1:nns_pkg::COORD_W], qy_reg);
        az_next = abs_diff(rdata_reg[nns_pkg::COORD_W-1:0], qz_reg);
        if (qdim_reg == nns_pkg::DIM_ONE)
        begin
            ay_next = '0;
        end
        if (qdim_reg != nns_pkg::DIM_THREE)
        begin
            az_next = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && (in_data.cmd == nns_pkg::CMD_QUERY))
        begin
            qx_reg   <= in_data.coord_x;
            qy_reg   <= in_data.coord_y;
            qz_reg   <= in_data.coord_z;
            qdim_reg <= (dim_reg == '0) ? nns_pkg::DIM_ONE : dim_reg;
            best_found_reg <= 1'b0;
            best_idx_reg   <= '0;
            best_dist_reg  <= nns_pkg::DIST_NONE;
        end
        else if (take_best)
        begin
            best_found_reg <= 1'b1;
            best_idx_reg   <= idx4_reg;
            best_dist_reg  <= sum_reg;
        end
        idx1_reg <= addr_reg[nns_pkg::ADDR_W-1:0];
        idx2_reg <= idx1_reg;
        idx3_reg <= idx2_reg;
        idx4_reg <= idx3_reg;
        ax_reg   <= ax_next;
        ay_reg   <= ay_next;
        az_reg   <= az_next;
        sqx_reg  <= ax_reg * ax_reg;
        sqy_reg  <= ay_reg * ay_reg;
        sqz_reg  <= az_reg * az_reg;
        sum_reg  <= nns_pkg::DIST_W'(sqx_reg) + nns_pkg::DIST_W'(sqy_reg)
                    + nns_pkg::DIST_W'(sqz_reg);
        if (out_load)
        begin
            out_data_reg.found         <= best_found_reg;
            out_data_reg.nearest_index <= nns_pkg::INDEX_W'(best_idx_reg);
            out_data_reg.sq_distance   <= best_dist_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ----- hdl/nns_checker.sv -----
// nns_checker: port-level assertions for nearest_node_search
// uses nns_pkg for payload types and command codes; bound to the top level

module nns_checker
(
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_valid,
    input logic                         in_ready,
    input nns_pkg::in_item_t            in_data,
    input logic                         out_valid,
    input logic                         out_ready,
    input nns_pkg::out_item_t           out_data
);

    // a query blocks further input while it scans
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && (in_data.cmd == nns_pkg::CMD_QUERY)) |=> !in_ready)
        else $error("input taken right after a query transaction");

    // empty table gives the DIST_NONE sentinel distance at index zero
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_data.found) |->
            ((out_data.sq_distance == nns_pkg::DIST_NONE) && (out_data.nearest_index == '0)))
        else $error("result without a node carries a wrong distance or index");

    // a new result only appears while input is held off
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("result appeared without a query in progress");

    // stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
        else $error("stalled result transaction changed");

endmodule

bind nearest_node_search nns_checker u_nns_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data)
);
